/* src/bdm_pkg.sv */
package bdm_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int REG_W      = 11;
    localparam int PIX_W      = 8;
    localparam int MIN_WIDTH  = 4;
    localparam int MIN_HEIGHT = 3;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;

    // Position flags of the pixel centered one row and one column back.
    typedef struct packed {
        logic x1;        // window column 1 is the left edge
        logic y1;        // window row 1 is the top edge
        logic xo;        // odd column
        logic yo;        // odd row
        logic last_row;
        logic last_col;
    } site_t;

    // One new window column plus the site it completes.
    typedef struct packed {
        logic  emit;
        site_t site;
        pix_t  older;
        pix_t  recent;
        pix_t  current;
    } col_item_t;

endpackage

/* src/bdm_stream_if.sv */
interface bdm_sample_if;
    logic         valid;
    logic         ready;
    bdm_pkg::pix_t pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface bdm_pixel_if;
    logic          valid;
    logic          ready;
    bdm_pkg::pix_t red;
    bdm_pkg::pix_t green;
    bdm_pkg::pix_t blue;
    logic          last_in_run;
    logic          frame_done;

    modport source (output valid, output red, output green, output blue,
                    output last_in_run, output frame_done, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_in_run, input frame_done, output ready);
endinterface

/* src/bdm_line_mem.sv */
module bdm_line_mem #(
    parameter int DEPTH = bdm_pkg::MAX_WIDTH_DEF,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bdm_emit.sv */
module bdm_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bdm_pkg::col_item_t item,
    output logic               take,
    bdm_pixel_if.source        pixels
);

    bdm_pkg::pix_t  taps_reg [3][3];
    logic           s2_valid_reg;
    bdm_pkg::site_t site_reg;
    logic [1:0]     idx_reg;

    logic           out_valid_reg;
    bdm_pkg::pix_t  red_reg;
    bdm_pkg::pix_t  green_reg;
    bdm_pkg::pix_t  blue_reg;
    logic           last_in_run_reg;
    logic           frame_done_reg;

    logic           out_load;
    logic           issue;
    logic [1:0]     n_last;
    logic           is_last;
    logic           rsel;
    logic           csel;
    logic [1:0]     ru, rm, rd, cl, cc, cr;
    logic           xo_e, yo_e;
    bdm_pkg::pix_t  vl, vc, vr, hs, ctr;
    bdm_pkg::pix_t  red_next, green_next, blue_next;

    function automatic bdm_pkg::pix_t avg2(bdm_pkg::pix_t a, bdm_pkg::pix_t b);
        logic [bdm_pkg::PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[bdm_pkg::PIX_W:1];
    endfunction

    // Results per item: 1, 2 (last row or last column) or 4 (both).
    assign n_last  = {site_reg.last_row & site_reg.last_col,
                      site_reg.last_row | site_reg.last_col};
    assign is_last = (idx_reg == n_last);
    assign rsel    = site_reg.last_row & idx_reg[0];
    assign csel    = site_reg.last_col & (site_reg.last_row ? idx_reg[1] : idx_reg[0]);

    assign out_load = !out_valid_reg || pixels.ready;
    assign issue    = s2_valid_reg && out_load;
    assign take     = !s2_valid_reg || (issue && is_last);

    always_comb
    begin
        // rsel: bottom row mirrors the row above; csel: right column mirrors the left.
        ru   = rsel ? 2'd1 : (site_reg.y1 ? 2'd2 : 2'd0);
        rm   = rsel ? 2'd2 : 2'd1;
        rd   = rsel ? 2'd1 : 2'd2;
        cl   = csel ? 2'd1 : (site_reg.x1 ? 2'd2 : 2'd0);
        cc   = csel ? 2'd2 : 2'd1;
        cr   = csel ? 2'd1 : 2'd2;
        yo_e = site_reg.yo ^ rsel;
        xo_e = site_reg.xo ^ csel;

        vl  = avg2(taps_reg[ru][cl], taps_reg[rd][cl]);
        vc  = avg2(taps_reg[ru][cc], taps_reg[rd][cc]);
        vr  = avg2(taps_reg[ru][cr], taps_reg[rd][cr]);
        hs  = avg2(taps_reg[rm][cl], taps_reg[rm][cr]);
        ctr = taps_reg[rm][cc];

        case ({yo_e, xo_e})
            2'b00:
            begin
                red_next   = hs;
                green_next = ctr;
                blue_next  = vc;
            end
            2'b01:
            begin
                red_next   = ctr;
                green_next = avg2(hs, vc);
                blue_next  = avg2(vl, vr);
            end
            2'b10:
            begin
                red_next   = avg2(vl, vr);
                green_next = avg2(hs, vc);
                blue_next  = ctr;
            end
            default:
            begin
                red_next   = vc;
                green_next = ctr;
                blue_next  = hs;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    taps_reg[r][c] <= '0;
                end
            end
            s2_valid_reg <= 1'b0;
            site_reg     <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    taps_reg[r][0] <= taps_reg[r][1];
                    taps_reg[r][1] <= taps_reg[r][2];
                end
                taps_reg[0][2] <= item.older;
                taps_reg[1][2] <= item.recent;
                taps_reg[2][2] <= item.current;
                s2_valid_reg   <= item.emit;
                site_reg       <= item.site;
                idx_reg        <= '0;
            end
            else if (issue && is_last)
            begin
                s2_valid_reg <= 1'b0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
            last_in_run_reg <= is_last;
            frame_done_reg  <= rsel & csel;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.red         = red_reg;
    assign pixels.green       = green_reg;
    assign pixels.blue        = blue_reg;
    assign pixels.last_in_run = last_in_run_reg;
    assign pixels.frame_done  = frame_done_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> idx_reg <= n_last)
        else $error("result index past item's count");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_done_reg |-> last_in_run_reg)
        else $error("frame end not on last result of its item");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        issue && !is_last |=> s2_valid_reg)
        else $error("item dropped before its last result");

endmodule

/* src/bayer_grbg_bilinear_demosaic_top.sv */
// GRBG bilinear demosaic: takes raw 8-bit Bayer samples of a frame in raster
// order and returns RGB pixels, each a nested floor average over its 3x3
// neighborhood with the frame edges mirrored onto the second row or column.
// Pixel (x,y) leaves when sample (x+1,y+1) is taken, so results lag by one row
// and one column; row 0 and column 0 samples produce nothing. A last-column
// sample yields two pixels, a last-row sample two (rows h-2 and h-1), the
// final sample four, with last_in_run on the last pixel of each run and
// frame_done on pixel (w-1,h-1). Rate: one sample per clock sustained while
// the output is ready; the output port moves one pixel per clock, so a sample
// with 2 or 4 pixels holds input until its last pixel is issued. Each sample
// passes line-store read, window shift and pixel math to the output register.
// Both previous rows live in a single 16-bit-wide line store, one entry per
// column, read when a sample is taken and written back when that sample moves
// into the window stage (the next cycle unless the window stage is still busy);
// no clearing pass is needed after reset. Writing frame_width or frame_height
// restarts the frame; write only while the block is idle. Out-of-range sizes
// saturate to 4..MAX_WIDTH and 3..MAX_HEIGHT.
module bayer_grbg_bilinear_demosaic_top #(
    parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bdm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bdm_sample_if.sink                samples,
    bdm_pixel_if.source               pixels,
    input  logic                      wr_en,
    input  logic                      wr_index,
    input  logic [bdm_pkg::REG_W-1:0] wr_data
);

    localparam int XW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XCW = (bdm_pkg::REG_W > XW + 1) ? bdm_pkg::REG_W : XW + 1;
    localparam int YCW = (bdm_pkg::REG_W > YW + 1) ? bdm_pkg::REG_W : YW + 1;
    localparam int LW  = 2 * bdm_pkg::PIX_W;

    // Config registers
    logic [bdm_pkg::REG_W-1:0] width_reg;
    logic [bdm_pkg::REG_W-1:0] height_reg;

    // Position of the next sample
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;

    // Stage 1: sample waiting on its line-store read
    logic           s1_valid_reg;
    logic           s1_emit_reg;
    bdm_pkg::site_t s1_site_reg;
    bdm_pkg::pix_t  s1_px_reg;
    logic [XW-1:0]  s1_col_reg;

    logic [XCW-1:0] w_ext, w_eff;
    logic [YCW-1:0] h_ext, h_eff;
    logic [XW-1:0]  col_last;
    logic [YW-1:0]  row_last;

    logic               accept;
    logic               s1_adv;
    logic               emit_take;
    logic [LW-1:0]      mem_rd;
    bdm_pkg::col_item_t item;
    bdm_pkg::site_t     site_now;

    // Saturate frame size
    always_comb
    begin
        w_ext = XCW'(width_reg);
        if (w_ext < XCW'(bdm_pkg::MIN_WIDTH))
            w_eff = XCW'(bdm_pkg::MIN_WIDTH);
        else if (w_ext > XCW'(MAX_WIDTH))
            w_eff = XCW'(MAX_WIDTH);
        else
            w_eff = w_ext;

        h_ext = YCW'(height_reg);
        if (h_ext < YCW'(bdm_pkg::MIN_HEIGHT))
            h_eff = YCW'(bdm_pkg::MIN_HEIGHT);
        else if (h_ext > YCW'(MAX_HEIGHT))
            h_eff = YCW'(MAX_HEIGHT);
        else
            h_eff = h_ext;
    end

    assign col_last = XW'(w_eff - XCW'(1));
    assign row_last = YW'(h_eff - YCW'(1));

    assign s1_adv        = s1_valid_reg && emit_take;
    assign samples.ready = !s1_valid_reg || s1_adv;
    assign accept        = samples.valid && samples.ready;

    // Site flags refer to pixel (col-1, row-1)
    always_comb
    begin
        site_now.x1       = (col_reg == XW'(1));
        site_now.y1       = (row_reg == YW'(1));
        site_now.xo       = ~col_reg[0];
        site_now.yo       = ~row_reg[0];
        site_now.last_row = (row_reg == row_last);
        site_now.last_col = (col_reg == col_last);

        col_next = col_reg + XW'(1);
        row_next = row_reg;
        if (site_now.last_col)
        begin
            col_next = '0;
            row_next = site_now.last_row ? '0 : row_reg + YW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bdm_pkg::REG_W'(320);
            height_reg <= bdm_pkg::REG_W'(240);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (bdm_pkg::reg_idx_t'(wr_index))
                bdm_pkg::REG_FRAME_WIDTH:  width_reg  <= wr_data;
                bdm_pkg::REG_FRAME_HEIGHT: height_reg <= wr_data;
                default:                   width_reg  <= width_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= (col_reg != '0) && (row_reg != '0);
            s1_site_reg <= site_now;
            s1_px_reg   <= samples.pixel_value;
            s1_col_reg  <= col_reg;
        end
    end

    // Entry = {row y-2, row y-1}; write back shifts the new sample in.
    bdm_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW),
        .DW    (LW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (mem_rd),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({mem_rd[bdm_pkg::PIX_W-1:0], s1_px_reg})
    );

    always_comb
    begin
        item.emit    = s1_emit_reg;
        item.site    = s1_site_reg;
        item.older   = mem_rd[LW-1:bdm_pkg::PIX_W];
        item.recent  = mem_rd[bdm_pkg::PIX_W-1:0];
        item.current = s1_px_reg;
    end

    bdm_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (s1_adv),
        .item   (item),
        .take   (emit_take),
        .pixels (pixels)
    );

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_adv |-> col_reg != s1_col_reg)
        else $error("line store read and write-back hit one entry");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= col_last)
        else $error("column counter beyond frame width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= row_last)
        else $error("row counter beyond frame height");

endmodule
